>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/bcld_pkg.sv
// Types and constants of the current limit derating block.
package bcld_pkg;

    localparam int DIV_NW = 40;  // dividend bits, one quotient bit per stage
    localparam int DIV_DW = 24;  // divisor bits
    localparam int N_INTERP = 4;

    localparam logic [2:0] REG_CURRENT_LIMITS  = 3'd0;
    localparam logic [2:0] REG_TEMP_THRESHOLDS = 3'd1;
    localparam logic [2:0] REG_VOLTAGE_LIMITS  = 3'd2;
    localparam logic [2:0] REG_CHARGE_TARGETS  = 3'd3;
    localparam logic [2:0] REG_CHARGER         = 3'd4;

    typedef struct packed {
        logic signed [15:0] low_temp;
        logic signed [15:0] high_temp;
        logic [15:0]        low_cell_mv;
        logic [15:0]        high_cell_mv;
        logic [15:0]        avg_cell_mv;
        logic               fault;
        logic               alt_charge_limit;
        logic               storage_mode;
        logic [7:0]         pilot_amps;
    } item_t;

    typedef struct packed {
        logic [15:0] discharge_limit;
        logic [15:0] charge_limit;
    } result_t;

    // Control carried alongside the dividers.
    typedef struct packed {
        logic                          dis_gate;
        logic                          chg_gate;
        logic [15:0]                   dis_max;
        logic [15:0]                   chg_full;
        logic [N_INTERP-1:0]           en;
        logic [N_INTERP-1:0]           zero;
        logic [N_INTERP-1:0]           sgn;
        logic [N_INTERP-1:0][15:0]     p;
        logic                          cap_en;
    } sb_t;

    typedef struct packed {
        logic                          dis_gate;
        logic                          chg_gate;
        logic [15:0]                   dis_max;
        logic [15:0]                   chg_full;
        logic [N_INTERP-1:0][39:0]     c;
        logic [38:0]                   cap;
        logic                          cap_en;
    } fin_t;

endpackage

>>> hw/rtl/bcld_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bcld_div
    import bcld_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
)
(
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [NW-1:0][DW-1:0] rem_reg, rem_next;
    logic [NW-1:0][NW-1:0] nq_reg, nq_next;
    logic [NW-1:0][DW-1:0] d_reg, d_next;

    always_comb
    begin
        logic [DW-1:0] r_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] d_in;
        logic [DW:0]   t;
        logic          ge;
        for (int i = 0; i < NW; i++)
        begin
            if (i == 0)
            begin
                r_in  = '0;
                nq_in = num;
                d_in  = den;
            end
            else
            begin
                r_in  = rem_reg[i-1];
                nq_in = nq_reg[i-1];
                d_in  = d_reg[i-1];
            end
            t  = {r_in, nq_in[NW-1]};
            ge = (t >= {1'b0, d_in});
            rem_next[i] = ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
            nq_next[i]  = {nq_in[NW-2:0], ge};
            d_next[i]   = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        d_reg   <= d_next;
    end

    assign quo = nq_reg[NW-1];

endmodule

>>> hw/rtl/battery_current_limit_derate.sv
// Top level of the battery current limit derating pipeline.
`include "assert_macros.svh"

// Battery current limit derating. One pack snapshot word is taken on every
// clock edge with start high (busy is never raised), and its result word
// appears on result for exactly one cycle with result_valid high. The
// pipeline is made up of the four front stages (input capture, window
// set-up, products, magnitudes), the 40 stages of the bit-per-stage
// dividers (one quotient bit each) and two closing stages (signed
// interpolation, then clamp, pilot cap and saturation). The receiver cannot
// stall, so nothing holds the pipe. Configuration is written through the cfg
// channel, which is always ready; write it only while no snapshot is in
// flight.
module battery_current_limit_derate
    import bcld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        result_valid,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int LAT = 4 + DIV_NW + 2;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [63:0] cl_reg, tt_reg, vl_reg;
    logic [47:0] ct_reg;
    logic [31:0] cs_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_reg <= '0;
            tt_reg <= '0;
            vl_reg <= '0;
            ct_reg <= '0;
            cs_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CURRENT_LIMITS:  cl_reg <= cfg_data;
                REG_TEMP_THRESHOLDS: tt_reg <= cfg_data;
                REG_VOLTAGE_LIMITS:  vl_reg <= cfg_data;
                REG_CHARGE_TARGETS:  ct_reg <= cfg_data[47:0];
                REG_CHARGER:         cs_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Valid chain: bit 0 is the input stage, top bit drives result_valid
    // ---------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start && !busy};
    end

    assign result_valid = vld_reg[LAT-1];

    // ---------------------------------------------------------------------
    // Stage 1: capture the snapshot
    // ---------------------------------------------------------------------
    item_t it_reg;

    always_ff @(posedge clk)
    begin
        it_reg <= item;
    end

    // ---------------------------------------------------------------------
    // Stage 2: hard limits and interpolation windows
    // Window k: 0 discharge/temp, 1 discharge/volt, 2 charge/temp,
    // 3 charge/volt (storage or normal target).
    // ---------------------------------------------------------------------
    logic [15:0]        dis_max, chg_full, chg_end;
    logic signed [15:0] t_under, t_over, t_dis, t_chg;
    logic [15:0]        v_over, v_under, v_floor, v_taper, v_chg, v_store, v_hys;
    logic [16:0]        v_taper_end;
    logic signed [18:0] t_lo19, t_hi19, v_lo19, v_hi19, v_start;
    logic               chg_zero, dis_zero;

    assign dis_max  = cl_reg[15:0];
    assign chg_full = it_reg.alt_charge_limit ? cl_reg[47:32] : cl_reg[31:16];
    assign chg_end  = cl_reg[63:48];
    assign t_under  = tt_reg[15:0];
    assign t_over   = tt_reg[31:16];
    assign t_dis    = tt_reg[47:32];
    assign t_chg    = tt_reg[63:48];
    assign v_over   = vl_reg[15:0];
    assign v_under  = vl_reg[31:16];
    assign v_floor  = vl_reg[47:32];
    assign v_taper  = vl_reg[63:48];
    assign v_chg    = ct_reg[15:0];
    assign v_store  = ct_reg[31:16];
    assign v_hys    = ct_reg[47:32];

    assign v_taper_end = {1'b0, v_floor} + {1'b0, v_taper};
    assign t_lo19  = 19'(it_reg.low_temp);
    assign t_hi19  = 19'(it_reg.high_temp);
    assign v_lo19  = $signed({3'b0, it_reg.low_cell_mv});
    assign v_hi19  = $signed({3'b0, it_reg.high_cell_mv});
    assign v_start = $signed({3'b0, it_reg.storage_mode ? v_store : v_chg})
                   - $signed({3'b0, v_hys});

    assign chg_zero = (it_reg.low_temp < t_under) || (it_reg.high_temp > t_over)
                   || (it_reg.high_cell_mv > v_over);
    assign dis_zero = (it_reg.high_temp > t_over) || (it_reg.low_cell_mv < v_under)
                   || (it_reg.low_cell_mv < v_floor);

    logic signed [N_INTERP-1:0][18:0] dx_next, db_next;
    logic signed [N_INTERP-1:0][17:0] dq_next;
    logic [N_INTERP-1:0][18:0]        dx2_reg, db2_reg;
    logic [N_INTERP-1:0][17:0]        dq2_reg;
    sb_t                              sb2_next, sb2_reg, sb3_reg, sb4_reg;
    logic [23:0]                      m1_reg, den2_reg;

    always_comb
    begin
        dx_next[0] = t_hi19 - 19'(t_dis);
        db_next[0] = 19'(t_over) - 19'(t_dis);
        dq_next[0] = $signed({2'b0, dis_max});
        dx_next[1] = v_lo19 - $signed({3'b0, v_floor});
        db_next[1] = $signed({3'b0, v_taper});
        dq_next[1] = -$signed({2'b0, dis_max});
        dx_next[2] = t_lo19 - 19'(t_under);
        db_next[2] = 19'(t_chg) - 19'(t_under);
        dq_next[2] = -$signed({2'b0, chg_full});
        dx_next[3] = v_hi19 - v_start;
        db_next[3] = $signed({3'b0, v_hys});
        dq_next[3] = $signed({2'b0, chg_full}) - $signed({2'b0, chg_end});

        sb2_next.dis_gate = !it_reg.fault && !dis_zero && (dis_max != '0);
        sb2_next.chg_gate = !it_reg.fault && !chg_zero && (chg_full != '0);
        sb2_next.dis_max  = dis_max;
        sb2_next.chg_full = chg_full;
        sb2_next.en[0]    = it_reg.high_temp > t_dis;
        sb2_next.en[1]    = {1'b0, it_reg.low_cell_mv} < v_taper_end;
        sb2_next.en[2]    = it_reg.low_temp < t_chg;
        sb2_next.en[3]    = v_hi19 > v_start;
        for (int k = 0; k < N_INTERP; k++)
            sb2_next.zero[k] = (db_next[k] == '0);
        sb2_next.sgn  = '0;
        sb2_next.p[0] = '0;
        sb2_next.p[1] = dis_max;
        sb2_next.p[2] = chg_full;
        sb2_next.p[3] = it_reg.storage_mode ? chg_end : 16'd0;
        sb2_next.cap_en = (it_reg.pilot_amps != '0);
    end

    always_ff @(posedge clk)
    begin
        dx2_reg  <= dx_next;
        db2_reg  <= db_next;
        dq2_reg  <= dq_next;
        sb2_reg  <= sb2_next;
        m1_reg   <= {8'b0, cs_reg[15:0]} * {16'b0, it_reg.pilot_amps};
        den2_reg <= {8'b0, it_reg.avg_cell_mv} * {16'b0, cs_reg[31:24]};
    end

    // ---------------------------------------------------------------------
    // Stage 3: products of the windows, pilot power
    // ---------------------------------------------------------------------
    logic signed [N_INTERP-1:0][36:0] prod3_reg;
    logic [N_INTERP-1:0][18:0]        db3_reg;
    logic [31:0]                      m2_reg;
    logic [23:0]                      den3_reg;
    sb_t                              sb3_next;

    always_comb
    begin
        sb3_next        = sb2_reg;
        sb3_next.cap_en = sb2_reg.cap_en && (den2_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N_INTERP; k++)
            prod3_reg[k] <= 37'($signed(dx2_reg[k])) * 37'($signed(dq2_reg[k]));
        db3_reg  <= db2_reg;
        m2_reg   <= {8'b0, m1_reg} * {24'b0, cs_reg[23:16]};
        den3_reg <= den2_reg;
        sb3_reg  <= sb3_next;
    end

    // ---------------------------------------------------------------------
    // Stage 4: magnitudes and quotient signs
    // ---------------------------------------------------------------------
    logic [N_INTERP-1:0][DIV_NW-1:0] num4_reg;
    logic [N_INTERP-1:0][DIV_DW-1:0] dv4_reg;
    logic [DIV_NW-1:0]               cnum4_reg;
    logic [DIV_DW-1:0]               cden4_reg;
    sb_t                             sb4_next;

    always_comb
    begin
        sb4_next = sb3_reg;
        for (int k = 0; k < N_INTERP; k++)
            sb4_next.sgn[k] = prod3_reg[k][36] ^ db3_reg[k][18];
    end

    always_ff @(posedge clk)
    begin
        sb4_reg <= sb4_next;
        for (int k = 0; k < N_INTERP; k++)
        begin
            num4_reg[k] <= DIV_NW'(prod3_reg[k][36] ? 37'(-prod3_reg[k]) : prod3_reg[k]);
            dv4_reg[k]  <= DIV_DW'(db3_reg[k][18] ? 19'(-db3_reg[k]) : db3_reg[k]);
        end
        cnum4_reg <= DIV_NW'({7'b0, m2_reg} * 39'd100);
        cden4_reg <= den3_reg;
    end

    // ---------------------------------------------------------------------
    // Dividers, with the control word delayed alongside
    // ---------------------------------------------------------------------
    logic [N_INTERP-1:0][DIV_NW-1:0] quo;
    logic [DIV_NW-1:0]               cquo;
    sb_t                             sbd_reg [DIV_NW];

    for (genvar k = 0; k < N_INTERP; k++)
    begin : g_div
        bcld_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div
        (
            .clk (clk),
            .num (num4_reg[k]),
            .den (dv4_reg[k]),
            .quo (quo[k])
        );
    end

    bcld_div #(.NW(DIV_NW), .DW(DIV_DW)) u_cap_div
    (
        .clk (clk),
        .num (cnum4_reg),
        .den (cden4_reg),
        .quo (cquo)
    );

    always_ff @(posedge clk)
    begin
        sbd_reg[0] <= sb4_reg;
        for (int i = 1; i < DIV_NW; i++)
            sbd_reg[i] <= sbd_reg[i-1];
    end

    // ---------------------------------------------------------------------
    // Closing stage 1: signed interpolation values (truncated towards zero)
    // ---------------------------------------------------------------------
    sb_t  sbe;
    fin_t fin_next, fin_reg;

    assign sbe = sbd_reg[DIV_NW-1];

    always_comb
    begin
        logic signed [39:0] qs;
        logic signed [39:0] pv;
        fin_next.dis_gate = sbe.dis_gate;
        fin_next.chg_gate = sbe.chg_gate;
        fin_next.dis_max  = sbe.dis_max;
        fin_next.chg_full = sbe.chg_full;
        fin_next.cap      = cquo[38:0];
        fin_next.cap_en   = sbe.cap_en;
        for (int k = 0; k < N_INTERP; k++)
        begin
            qs = $signed({4'b0, quo[k][35:0]});
            if (sbe.sgn[k])
                qs = -qs;
            pv = $signed({24'b0, sbe.p[k]});
            if (!sbe.en[k])
                fin_next.c[k] = '0;
            else if (sbe.zero[k])
                fin_next.c[k] = pv;
            else
                fin_next.c[k] = qs + pv;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    // ---------------------------------------------------------------------
    // Closing stage 2: combine, clamp at zero, pilot cap, saturate
    // ---------------------------------------------------------------------
    result_t res_next, res_reg;

    always_comb
    begin
        logic signed [39:0] dis;
        logic signed [39:0] chg;
        dis = '0;
        chg = '0;
        if (fin_reg.dis_gate)
            dis = $signed({24'b0, fin_reg.dis_max}) - $signed(fin_reg.c[0])
                - $signed(fin_reg.c[1]);
        if (fin_reg.chg_gate)
            chg = $signed({24'b0, fin_reg.chg_full}) - $signed(fin_reg.c[2])
                - $signed(fin_reg.c[3]);
        if (dis[39])
            dis = '0;
        if (chg[39])
            chg = '0;
        if (fin_reg.cap_en && (chg[38:0] > fin_reg.cap))
            chg = $signed({1'b0, fin_reg.cap});
        res_next.discharge_limit = (dis[39:16] != '0) ? 16'hFFFF : dis[15:0];
        res_next.charge_limit    = (chg[39:16] != '0) ? 16'hFFFF : chg[15:0];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_enters, clk, rst_n, start, vld_reg[0])
    `ASSERT_IMPL(a_latency, clk, rst_n, result_valid, $past(vld_reg[0], LAT - 1))
    `ASSERT_NEXT(a_dis_gate_zero, clk, rst_n, vld_reg[LAT-2] && !fin_reg.dis_gate,
                 result.discharge_limit == 16'd0)
    `ASSERT_NEXT(a_chg_gate_zero, clk, rst_n, vld_reg[LAT-2] && !fin_reg.chg_gate,
                 result.charge_limit == 16'd0)

endmodule
